// ===== src/gated_nearest_track_association_core_macros.svh =====
// assertion macros for the gated nearest track association core
// used by the port checker, no other dependencies
`ifndef GATED_NEAREST_TRACK_ASSOCIATION_CORE_MACROS_SVH
`define GATED_NEAREST_TRACK_ASSOCIATION_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define GNTA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define GNTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gnta_pkg.sv =====
// shared widths and register codes for the track association core
// no dependencies
package gnta_pkg;

  localparam int COORD_W    = 24;
  localparam int DIST_W     = 52;
  localparam int PERIOD_W   = 10;
  localparam int LIMIT_W    = 4;
  localparam int TRACK_W    = 6;
  localparam int CNT_OUT_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 52;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_GATE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 3'd3;

  localparam logic [DIST_W-1:0]   GATE_RESET   = 52'd65536;
  localparam logic [DIST_W-1:0]   SEARCH_RESET = 52'd104857600;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd100;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 4'd5;

  localparam logic [COORD_W-1:0] VEL_MAX = 24'h7FFFFF;
  localparam logic [COORD_W-1:0] VEL_MIN = 24'h800000;

endpackage

// ===== src/gnta_if.sv =====
// item channels and configuration write channel of the association core
// depends on gnta_pkg
interface box_if;
  import gnta_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] box_x;
  logic signed [COORD_W-1:0] box_y;
  logic                      last_in_frame;
  modport source (output valid, box_x, box_y, last_in_frame, input ready);
  modport sink   (input valid, box_x, box_y, last_in_frame, output ready);
endinterface

interface result_if;
  import gnta_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [COORD_W-1:0]   velocity_x;
  logic signed [COORD_W-1:0]   velocity_y;
  logic                        matched;
  logic [TRACK_W-1:0]          matched_track;
  logic [TRACK_W-1:0]          track_slot;
  logic [CNT_OUT_W-1:0]        history_count;
  logic                        dropped;
  modport source (output valid, velocity_x, velocity_y, matched, matched_track,
                  track_slot, history_count, dropped, input ready);
  modport sink   (input valid, velocity_x, velocity_y, matched, matched_track,
                  track_slot, history_count, dropped, output ready);
endinterface

interface cfg_if;
  import gnta_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/gated_nearest_track_association_core.sv =====
// gated nearest track association core: top level, sequencer and track stores
// depends on gnta_pkg, gnta_if, gnta_sqr, gnta_div
//
// usage
// - box_in carries one detected box centre per item; last_in_frame closes a frame
//   and the current and previous track banks swap once that item's result is taken
// - result_out carries one result item per box: velocity, match, slot, history length
// - cfg writes the four registers by index; write only while the block is idle,
//   cfg.ready is always high
// - one item at a time: box_in.ready is high only while idle
// - per item the sequencer runs a search loop over the previous-frame tracks (one
//   read of the history memory and two passes through the shared squarer per
//   track), copies the kept history entries of a matched track and, when the
//   history holds more than one entry, runs the two velocity divisions on the
//   bit-serial divider; the next item is taken only once the result has left
//   and the block is idle again
// - a box arriving when the frame already holds MAX_TRACKS tracks goes from S_IDLE
//   straight to S_OUT and is answered with dropped set and nothing stored
// - reset (rst, synchronous) clears the sequencer, track counts and bank select and
//   restores register defaults; the history stores are not cleared, only written
//   entries are ever read
// - when result_out.ready is low the result item holds and no new item is taken
module gated_nearest_track_association_core #(
  parameter int MAX_TRACKS    = 64,
  parameter int HISTORY_DEPTH = 8
) (
  input  logic     clk,
  input  logic     rst,
  box_if.sink      box_in,
  result_if.source result_out,
  cfg_if.sink      cfg
);
  import gnta_pkg::*;

  localparam int SLOT_W  = $clog2(MAX_TRACKS);
  localparam int TCNT_W  = $clog2(MAX_TRACKS + 1);
  localparam int K_W     = $clog2(HISTORY_DEPTH);
  localparam int HCNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int ADDR_W  = 1 + SLOT_W + K_W;
  localparam int LADDR_W = 1 + SLOT_W;
  localparam int NUM_W   = COORD_W + 11;
  localparam int DEN_W   = PERIOD_W + HCNT_W;
  localparam int SQ_W    = 2 * COORD_W + 1;
  localparam logic [4:0] DEPTH5 = 5'(HISTORY_DEPTH);

  // one-hot sequencer
  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_SRD  = 15'b000000000000010,
    S_SDAT = 15'b000000000000100,
    S_SQX  = 15'b000000000001000,
    S_SQY  = 15'b000000000010000,
    S_DEC  = 15'b000000000100000,
    S_LEN  = 15'b000000001000000,
    S_CRD  = 15'b000000010000000,
    S_CWR  = 15'b000000100000000,
    S_WR0  = 15'b000001000000000,
    S_DXS  = 15'b000010000000000,
    S_DXW  = 15'b000100000000000,
    S_DYS  = 15'b001000000000000,
    S_DYW  = 15'b010000000000000,
    S_OUT  = 15'b100000000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [DIST_W-1:0]   gate_dist_sq;
  logic [DIST_W-1:0]   search_dist_sq;
  logic [PERIOD_W-1:0] frame_period_ms;
  logic [LIMIT_W-1:0]  history_limit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_dist_sq    <= GATE_RESET;
      search_dist_sq  <= SEARCH_RESET;
      frame_period_ms <= PERIOD_RESET;
      history_limit   <= LIMIT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_GATE:   gate_dist_sq    <= cfg.data[DIST_W-1:0];
        CFG_SEARCH: search_dist_sq  <= cfg.data[DIST_W-1:0];
        CFG_PERIOD: frame_period_ms <= cfg.data[PERIOD_W-1:0];
        CFG_LIMIT:  history_limit   <= cfg.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // frame bookkeeping
  logic [TCNT_W-1:0] prev_count;
  logic [TCNT_W-1:0] cur_count;
  logic              bank;

  // item registers
  logic [COORD_W-1:0] bx;
  logic [COORD_W-1:0] by;
  logic               last;
  logic [SLOT_W-1:0]  slot;
  logic [SLOT_W-1:0]  j;
  logic [SLOT_W-1:0]  best_j;
  logic [DIST_W-1:0]  best;
  logic               found;
  logic signed [COORD_W:0] dx;
  logic signed [COORD_W:0] dy;
  logic [SQ_W-1:0]    sq_acc;
  logic [HCNT_W-1:0]  keep;
  logic [HCNT_W-1:0]  k;
  logic [HCNT_W-1:0]  count;
  logic [2*COORD_W-1:0] old;
  logic signed [COORD_W:0] diff_x;
  logic signed [COORD_W:0] diff_y;
  logic [DEN_W-1:0]   den;

  // result registers
  logic [COORD_W-1:0] vel_x;
  logic [COORD_W-1:0] vel_y;
  logic               matched_r;
  logic               dropped_r;

  // history memory: {bank, slot, age} -> packed {y, x}
  logic [2*COORD_W-1:0] hist_mem [2**ADDR_W];
  logic [2*COORD_W-1:0] hist_rdata;
  logic [ADDR_W-1:0]    hist_raddr;
  logic [ADDR_W-1:0]    hist_waddr;
  logic [2*COORD_W-1:0] hist_wdata;
  logic                 hist_we;

  // history length memory: {bank, slot} -> length
  logic [HCNT_W-1:0]  len_mem [2**LADDR_W];
  logic [HCNT_W-1:0]  len_rdata;
  logic               len_we;

  always_comb begin
    if (state == S_SRD) begin
      hist_raddr = {~bank, j, K_W'(0)};
    end else begin
      hist_raddr = {~bank, best_j, k[K_W-1:0]};
    end
    hist_we = (state == S_CWR) || (state == S_WR0);
    if (state == S_CWR) begin
      hist_waddr = {bank, slot, K_W'(k + 1'b1)};
      hist_wdata = hist_rdata;
    end else begin
      hist_waddr = {bank, slot, K_W'(0)};
      hist_wdata = {by, bx};
    end
  end

  assign len_we = (state == S_WR0);

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_rdata <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    // new length is the kept entries plus the box itself
    if (len_we) len_mem[{bank, slot}] <= keep + 1'b1;
    // best_j is settled by the time the length is needed
    len_rdata <= len_mem[{~bank, best_j}];
  end

  // shared squarer, x then y of each candidate
  logic signed [COORD_W:0] sq_op;
  logic [SQ_W-1:0]         sq;
  logic [DIST_W-1:0]       cand_dist;

  assign sq_op     = (state == S_SQX) ? dx : dy;
  assign cand_dist = DIST_W'(sq_acc) + DIST_W'(sq);

  gnta_sqr u_sqr (
    .a  (sq_op),
    .sq (sq)
  );

  // velocity division, x then y through one divider
  logic [COORD_W:0]   mag_x;
  logic [COORD_W:0]   mag_y;
  logic [NUM_W-1:0]   div_num;
  logic [NUM_W-1:0]   div_quo;
  logic               div_start;
  logic               div_done;

  assign mag_x     = diff_x[COORD_W] ? (COORD_W+1)'(-diff_x) : diff_x;
  assign mag_y     = diff_y[COORD_W] ? (COORD_W+1)'(-diff_y) : diff_y;
  assign div_start = (state == S_DXS) || (state == S_DYS);
  assign div_num   = (state == S_DXS) ? NUM_W'(mag_x) * NUM_W'(1000)
                                      : NUM_W'(mag_y) * NUM_W'(1000);

  gnta_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (den),
    .quo   (div_quo),
    .done  (div_done)
  );

  // truncated quotient back to a signed, saturated velocity
  function automatic logic [COORD_W-1:0] sat_vel(input logic neg, input logic [NUM_W-1:0] q);
    logic [COORD_W-1:0] r;
    if (neg) begin
      if (q > NUM_W'(VEL_MIN)) r = VEL_MIN;
      else r = COORD_W'(-q);
    end else begin
      if (q > NUM_W'(VEL_MAX)) r = VEL_MAX;
      else r = q[COORD_W-1:0];
    end
    return r;
  endfunction

  // history limit and stored length clamps
  logic [4:0] lim5;
  logic [4:0] plen5;
  logic [4:0] keep5;
  logic [PERIOD_W-1:0] period;
  logic [HCNT_W-1:0] count_new;
  logic              in_acc;
  logic              full;

  always_comb begin
    if (history_limit == '0) lim5 = 5'd1;
    else if (5'(history_limit) > DEPTH5) lim5 = DEPTH5;
    else lim5 = 5'(history_limit);
    plen5 = (5'(len_rdata) > DEPTH5) ? DEPTH5 : 5'(len_rdata);
    keep5 = (plen5 < lim5 - 5'd1) ? plen5 : lim5 - 5'd1;
  end

  assign period    = (frame_period_ms == '0) ? PERIOD_W'(1) : frame_period_ms;
  assign count_new = keep + 1'b1;
  assign in_acc    = box_in.valid && box_in.ready;
  assign full      = (cur_count >= TCNT_W'(MAX_TRACKS));

  assign box_in.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      prev_count <= '0;
      cur_count  <= '0;
      bank       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (full) state <= S_OUT;
            else if (prev_count == '0) state <= S_DEC;
            else state <= S_SRD;
          end
        end
        S_SRD:  state <= S_SDAT;
        S_SDAT: state <= S_SQX;
        S_SQX:  state <= S_SQY;
        S_SQY: begin
          if (TCNT_W'(j) + 1'b1 >= prev_count) state <= S_DEC;
          else state <= S_SRD;
        end
        S_DEC: begin
          if (found && best <= gate_dist_sq) state <= S_LEN;
          else state <= S_WR0;
        end
        S_LEN: begin
          if (keep5 == 5'd0) state <= S_WR0;
          else state <= S_CRD;
        end
        S_CRD: state <= S_CWR;
        S_CWR: begin
          if (k + 1'b1 >= keep) state <= S_WR0;
          else state <= S_CRD;
        end
        S_WR0: begin
          cur_count <= cur_count + 1'b1;
          if (count_new > HCNT_W'(1)) state <= S_DXS;
          else state <= S_OUT;
        end
        S_DXS: state <= S_DXW;
        S_DXW: if (div_done) state <= S_DYS;
        S_DYS: state <= S_DYW;
        S_DYW: if (div_done) state <= S_OUT;
        S_OUT: begin
          if (result_out.ready) begin
            state <= S_IDLE;
            // bank swap once the closing item has left
            if (last) begin
              prev_count <= cur_count;
              cur_count  <= '0;
              bank       <= ~bank;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          bx        <= box_in.box_x;
          by        <= box_in.box_y;
          last      <= box_in.last_in_frame;
          slot      <= full ? '0 : cur_count[SLOT_W-1:0];
          dropped_r <= full;
          j         <= '0;
          best_j    <= '0;
          best      <= search_dist_sq;
          found     <= 1'b0;
          matched_r <= 1'b0;
          keep      <= '0;
          k         <= '0;
          count     <= HCNT_W'(1);
          vel_x     <= '0;
          vel_y     <= '0;
        end
      end
      S_SDAT: begin
        dx <= {bx[COORD_W-1], bx} - {hist_rdata[COORD_W-1], hist_rdata[COORD_W-1:0]};
        dy <= {by[COORD_W-1], by}
              - {hist_rdata[2*COORD_W-1], hist_rdata[2*COORD_W-1:COORD_W]};
      end
      S_SQX: sq_acc <= sq;
      S_SQY: begin
        // strict compare keeps the lowest index on ties
        if (cand_dist < best) begin
          best   <= cand_dist;
          best_j <= j;
          found  <= 1'b1;
        end
        j <= j + 1'b1;
      end
      S_DEC: matched_r <= found && (best <= gate_dist_sq);
      S_LEN: keep <= HCNT_W'(keep5);
      S_CWR: begin
        old <= hist_rdata;
        k   <= k + 1'b1;
      end
      S_WR0: begin
        count  <= count_new;
        diff_x <= {bx[COORD_W-1], bx} - {old[COORD_W-1], old[COORD_W-1:0]};
        diff_y <= {by[COORD_W-1], by} - {old[2*COORD_W-1], old[2*COORD_W-1:COORD_W]};
        den    <= DEN_W'(period) * DEN_W'(keep);
      end
      S_DXW: if (div_done) vel_x <= sat_vel(diff_x[COORD_W], div_quo);
      S_DYW: if (div_done) vel_y <= sat_vel(diff_y[COORD_W], div_quo);
      default: ;
    endcase
  end

  assign result_out.valid         = (state == S_OUT);
  assign result_out.velocity_x    = vel_x;
  assign result_out.velocity_y    = vel_y;
  assign result_out.matched       = matched_r;
  assign result_out.matched_track = matched_r ? TRACK_W'(best_j) : '0;
  assign result_out.track_slot    = TRACK_W'(slot);
  assign result_out.history_count = CNT_OUT_W'(count);
  assign result_out.dropped       = dropped_r;
endmodule

// ===== src/gnta_sqr.sv =====
// shared squaring unit for the distance search
// depends on gnta_pkg
module gnta_sqr (
  input  logic signed [gnta_pkg::COORD_W:0]   a,
  output logic        [2*gnta_pkg::COORD_W:0] sq
);
  import gnta_pkg::*;

  logic signed [2*COORD_W+1:0] prod;

  assign prod = a * a;
  // square is never negative, top bit is sign only
  assign sq = prod[2*COORD_W:0];
endmodule

// ===== src/gnta_div.sv =====
// restoring divider, one quotient bit a cycle
// no package dependencies
module gnta_div #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W+1:0] sub;
  logic             ge;

  assign sub = {1'b0, rem, quo[NUM_W-1]} - {2'b00, den_r};
  assign ge  = ~sub[DEN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? sub[DEN_W-1:0] : {rem[DEN_W-2:0], quo[NUM_W-1]};
      quo <= {quo[NUM_W-2:0], ge};
    end
  end
endmodule

// ===== src/gnta_checker.sv =====
// port-level checker for the association core, bound to the top level
// depends on gated_nearest_track_association_core_macros.svh
`include "gated_nearest_track_association_core_macros.svh"

module gnta_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       matched,
  input logic [5:0] matched_track,
  input logic [3:0] history_count,
  input logic       dropped
);
  // one item in flight: never ready while a result waits
  `GNTA_ASSERT_NOW(a_one_in_flight, out_valid, !in_ready, "ready while result pending")
  // an accepted item leaves the input not ready in the following cycle
  `GNTA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  // stalled result stays offered
  `GNTA_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid, "result dropped on stall")
  // a dropped box reports a bare unmatched history
  `GNTA_ASSERT_NOW(a_dropped_fields, out_valid && dropped,
    !matched && matched_track == 6'd0 && history_count == 4'd1, "dropped item fields")
endmodule

bind gated_nearest_track_association_core gnta_checker u_gnta_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (box_in.valid),
  .in_ready      (box_in.ready),
  .out_valid     (result_out.valid),
  .out_ready     (result_out.ready),
  .matched       (result_out.matched),
  .matched_track (result_out.matched_track),
  .history_count (result_out.history_count),
  .dropped       (result_out.dropped)
);
